// ===== design/i2da_pkg.sv =====
`default_nettype none
package i2da_pkg;

	// ASCII codes used in the text
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// input word: raw number and how to read it
	typedef struct packed {
		logic [63:0] value;
		logic        is_signed;
	} in_word_t;

	// output word: one character of the text
	typedef struct packed {
		logic [7:0] text_char;
		logic       last;
	} out_word_t;

	// sequencer commands to the conversion unit
	typedef struct packed {
		logic load;
		logic step;
		logic digit_shift;
	} i2da_cmd_t;

endpackage
`default_nettype wire

// ===== design/i2da_bcd_unit.sv =====
`default_nettype none
// Shift-add-3 binary to BCD unit: one binary bit per step, plus a
// digit shift that moves the BCD word up by one digit.
module i2da_bcd_unit #(
	parameter int VALUE_BITS = 64,
	parameter int NDIG       = 20
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire i2da_pkg::i2da_cmd_t     cmd,
	input  wire logic [VALUE_BITS-1:0]   mag,
	output logic      [3:0]              top_digit
);

	logic [VALUE_BITS-1:0] bin_q;
	logic [4*NDIG-1:0]     bcd_q;
	logic [4*NDIG-1:0]     bcd_adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		logic [3:0] dig;
		bcd_adj = bcd_q;
		for (int i = 0; i < NDIG; i++) begin
			dig = bcd_q[4*i +: 4];
			if (dig >= 4'd5) begin
				bcd_adj[4*i +: 4] = dig + 4'd3;
			end
		end
	end

	// working registers: binary shifter and BCD accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[4*NDIG-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.digit_shift) begin
			bcd_q <= {bcd_q[4*NDIG-5:0], 4'h0};
		end
	end

	assign top_digit = bcd_q[4*NDIG-1 -: 4];

endmodule
`default_nettype wire

// ===== design/int64_to_decimal_ascii_top.sv =====
`default_nettype none
// Binary to decimal ASCII converter. Each input word is one number,
// read as two's complement or unsigned per is_signed, using its low
// VALUE_BITS bits. The output is its decimal text, one character per
// word, most significant digit first, no leading zeros, '-' first for a
// negative value, last set on the final character. A number is accepted,
// run through the shift-add-3 loop one bit per step over VALUE_BITS bits,
// its leading zero digits are skipped, a minus sign is sent when it is
// negative, and then its digits are sent while the output is taken; the
// receiver can stall the output. in_ready is high only between numbers;
// the last character can still wait in the output register while the
// next number is accepted.
module int64_to_decimal_ascii_top #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire i2da_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output i2da_pkg::out_word_t      out_data
);

	localparam int NDIG      = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(NDIG + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic                   neg_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic                   out_valid_q;
	i2da_pkg::out_word_t    out_q;

	logic [VALUE_BITS-1:0]  raw;
	logic                   neg;
	logic [VALUE_BITS-1:0]  mag;
	logic                   in_fire;
	logic                   out_free;
	logic                   out_load;
	logic                   skip;
	logic [3:0]             top_digit;
	i2da_pkg::i2da_cmd_t    cmd;

	// magnitude of the incoming number
	assign raw     = in_data.value[VALUE_BITS-1:0];
	assign neg     = in_data.is_signed & raw[VALUE_BITS-1];
	assign mag     = neg ? (~raw + 1'b1) : raw;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign out_load = ((state_q == ST_SIGN) || (state_q == ST_EMIT)) && out_free;
	assign skip     = (top_digit == 4'h0) && (dig_cnt_q > DIG_CNT_W'(1));

	// commands to the conversion unit
	always_comb begin
		cmd.load        = in_fire;
		cmd.step        = (state_q == ST_CONV);
		cmd.digit_shift = ((state_q == ST_SKIP) && skip) ||
		                  ((state_q == ST_EMIT) && out_free);
	end

	i2da_bcd_unit #(
		.VALUE_BITS (VALUE_BITS),
		.NDIG       (NDIG)
	) u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mag       (mag),
		.top_digit (top_digit)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			neg_q       <= 1'b0;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
		end else begin
			// output valid: set on a new character, cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q     <= neg;
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
						dig_cnt_q <= DIG_CNT_W'(NDIG);
						state_q   <= ST_SKIP;
					end else begin
						bit_cnt_q <= bit_cnt_q + 1'b1;
					end
				end
				ST_SKIP: begin
					if (skip) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_q.text_char <= i2da_pkg::CHAR_MINUS;
						out_q.last      <= 1'b0;
						state_q         <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.text_char <= i2da_pkg::CHAR_ZERO + {4'h0, top_digit};
						out_q.last      <= (dig_cnt_q == DIG_CNT_W'(1));
						dig_cnt_q       <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == DIG_CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
